// ===== sv/lti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lti_pkg
// Operation codes and fixed field widths of the letter trie.
// ----------------------------------------------------------------------------
package lti_pkg;

	localparam int FUNC_W   = 2;
	localparam int LETTER_W = 5;

	typedef logic [FUNC_W-1:0]   func_t;
	typedef logic [LETTER_W-1:0] letter_t;

	localparam func_t FUNC_INSERT = 2'd0;
	localparam func_t FUNC_SEARCH = 2'd1;
	localparam func_t FUNC_PREFIX = 2'd2;

endpackage

// ===== sv/letter_trie_insert_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_trie_insert_search
// Prefix trie held as a node table; insert, whole-word search, prefix search (func code 3 acts as prefix search).
// ----------------------------------------------------------------------------
// Words enter one letter per item on the letter channel (func, letter,
// last_letter; valid/stall). Only the last letter of a word gives a result
// item on the result channel (found, status; valid/stall).
// Each node is one row of a simple dual-port synchronous memory: one child
// link per letter plus the word-end mark. As it takes a letter, the idle
// state reads the current node's row; the look state then follows or
// allocates the link and writes the row back. A last letter adds a final
// step: the look state also reads the final node's row, and the final state
// sets its mark on an insert and loads the result register. Memory reads are registered.
// Letters are taken one at a time; a new letter is accepted while an earlier
// result still waits in the output register.
// When the receiver stalls, the result is held and a following last letter
// waits in its final step until the register is free.
// After reset the block clears the table one row a cycle, every row once,
// with letter_stall high; the walk returns to the root and one node is used.
// ----------------------------------------------------------------------------
module letter_trie_insert_search #(
	parameter int NODE_COUNT    = 1024,
	parameter int ALPHABET_SIZE = 26
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    letter_valid,
	output logic                    letter_stall,
	input  lti_pkg::func_t          func,
	input  lti_pkg::letter_t        letter,
	input  logic                    last_letter,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic                    found,
	output logic                    status
);

	localparam int NW    = $clog2(NODE_COUNT);
	localparam int CW    = $clog2(NODE_COUNT + 1);
	localparam int LW    = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int XW    = lti_pkg::LETTER_W + LW;
	localparam int ROW_W = ALPHABET_SIZE * NW + 1;
	localparam int MARK  = ROW_W - 1;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_LOOK  = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [ROW_W-1:0] mem [NODE_COUNT];

	logic [1:0]             state_q;
	logic [NW-1:0]          clr_q;
	logic [NW-1:0]          cur_q;
	logic [CW-1:0]          used_q;
	logic                   miss_q;
	logic                   full_q;
	lti_pkg::func_t         func_q;
	lti_pkg::letter_t       letter_q;
	logic                   last_q;
	logic [ROW_W-1:0]       row_q;
	logic                   out_valid_q;
	logic                   found_q;
	logic                   status_q;

	logic [XW-1:0]          letter_x;
	logic [LW-1:0]          lidx;
	logic                   in_range;
	logic [NW-1:0]          link;
	logic                   is_insert;
	logic                   pool_empty;
	logic [NW-1:0]          cur_next;
	logic                   miss_next;
	logic                   full_next;
	logic                   alloc;
	logic                   fin_go;
	logic                   wr_en;
	logic [NW-1:0]          wr_addr;
	logic [ROW_W-1:0]       wr_data;
	logic [NW-1:0]          rd_addr;

	assign letter_x   = XW'(letter_q);
	assign lidx       = letter_x[LW-1:0];
	assign in_range   = letter_x < XW'(ALPHABET_SIZE);
	assign link       = row_q[lidx*NW +: NW];
	assign is_insert  = func_q == lti_pkg::FUNC_INSERT;
	assign pool_empty = used_q >= CW'(NODE_COUNT);
	assign fin_go     = (state_q == S_FIN) && (!out_valid_q || !result_stall);

	always_comb begin
		cur_next  = cur_q;
		miss_next = miss_q;
		full_next = full_q;
		alloc     = 1'b0;
		if (!miss_q && !full_q) begin
			if (!in_range) begin
				miss_next = 1'b1;
			end else if (link != '0) begin
				cur_next = link;
			end else if (!is_insert) begin
				miss_next = 1'b1;
			end else if (pool_empty) begin
				full_next = 1'b1;
			end else begin
				alloc    = 1'b1;
				cur_next = used_q[NW-1:0];
			end
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = row_q;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			S_LOOK: begin
				wr_en = alloc;
				wr_data[lidx*NW +: NW] = used_q[NW-1:0];
			end
			S_FIN: begin
				wr_en = fin_go && is_insert && !full_q && !miss_q;
				wr_data[MARK] = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign rd_addr = (state_q == S_LOOK) ? cur_next : cur_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		row_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cur_q       <= '0;
			used_q      <= CW'(1);
			miss_q      <= 1'b0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (result_valid && !result_stall && !fin_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == NW'(NODE_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (letter_valid) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					cur_q  <= cur_next;
					miss_q <= miss_next;
					full_q <= full_next;
					if (alloc) begin
						used_q <= used_q + CW'(1);
					end
					state_q <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						cur_q       <= '0;
						miss_q      <= 1'b0;
						full_q      <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && letter_valid) begin
			func_q   <= func;
			letter_q <= letter;
			last_q   <= last_letter;
		end
		if (fin_go) begin
			if (is_insert) begin
				found_q  <= !full_q && !miss_q;
				status_q <= full_q;
			end else begin
				status_q <= 1'b0;
				if (miss_q || full_q) begin
					found_q <= 1'b0;
				end else if (func_q == lti_pkg::FUNC_SEARCH) begin
					found_q <= row_q[MARK];
				end else begin
					found_q <= 1'b1;
				end
			end
		end
	end

	assign letter_stall = state_q != S_IDLE;
	assign result_valid = out_valid_q;
	assign found        = found_q;
	assign status       = status_q;

endmodule

// ===== bench/letter_trie_insert_search_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_trie_insert_search_tb
// Self-checking bench for the letter trie: insert, word search, prefix search.
// ----------------------------------------------------------------------------
// Words are sent one letter per item. A scoreboard keeps its own copy of the
// node table and predicts the result of every word's last letter. Directed
// words cover the edge cases. Random words follow under three idle patterns.
// A final phase fills the node pool with fresh inserts and then keeps
// hitting the full pool. Results are checked in order, field by field.
// ----------------------------------------------------------------------------
module letter_trie_insert_search_tb;

	localparam int NODES          = 1024;
	localparam int ALPHA          = 26;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;
	localparam int PRINT_LIMIT    = 50;
	localparam lti_pkg::func_t FUNC_SPARE = 2'd3;

	typedef struct packed {
		logic found;
		logic status;
	} outcome_t;

	class trie_scoreboard;
		int unsigned links [NODES*ALPHA];
		bit          marks [NODES];
		int unsigned node;
		bit          off_path;
		bit          out_of_nodes;
		int unsigned used;
		outcome_t    outcomes [$];
		int          errors;
		int          results;
		int          hits;
		int          full_inserts;

		function new();
			foreach (links[i])
				links[i] = 0;
			foreach (marks[i])
				marks[i] = 1'b0;
			node = 0;
			off_path = 1'b0;
			out_of_nodes = 1'b0;
			used = 1;
			errors = 0;
			results = 0;
			hits = 0;
			full_inserts = 0;
		endfunction

		function int pending();
			return outcomes.size();
		endfunction

		task report(string what);
			errors++;
			if (errors <= PRINT_LIMIT)
				$display("tb: mismatch at %0t: %s", $realtime, what);
		endtask

		task note_letter(lti_pkg::func_t op, lti_pkg::letter_t l, logic last);
			int unsigned slot;
			int unsigned nxt;
			outcome_t    o;
			if (!off_path && !out_of_nodes) begin
				if (l >= ALPHA) begin
					off_path = 1'b1;
				end else begin
					slot = node * ALPHA + l;
					nxt = links[slot];
					if (nxt == 0) begin
						if (op != lti_pkg::FUNC_INSERT) begin
							off_path = 1'b1;
						end else if (used >= NODES) begin
							out_of_nodes = 1'b1;
						end else begin
							nxt = used;
							links[slot] = nxt;
							used++;
						end
					end
					if (!off_path && !out_of_nodes)
						node = nxt;
				end
			end
			if (last) begin
				o = '0;
				if (op == lti_pkg::FUNC_INSERT) begin
					if (out_of_nodes) begin
						o.status = 1'b1;
						full_inserts++;
					end else if (!off_path) begin
						marks[node] = 1'b1;
						o.found = 1'b1;
					end
				end else if (!off_path && !out_of_nodes) begin
					o.found = (op == lti_pkg::FUNC_SEARCH) ? marks[node] : 1'b1;
					if (o.found)
						hits++;
				end
				outcomes.push_back(o);
				node = 0;
				off_path = 1'b0;
				out_of_nodes = 1'b0;
			end
		endtask

		task check_result(logic f, logic s);
			outcome_t o;
			results++;
			if (outcomes.size() == 0) begin
				report($sformatf("result found=%b status=%b with nothing expected", f, s));
			end else begin
				o = outcomes.pop_front();
				if (f !== o.found)
					report($sformatf("found %b, expected %b", f, o.found));
				if (s !== o.status)
					report($sformatf("status %b, expected %b", s, o.status));
			end
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             letter_valid;
	logic             letter_stall;
	lti_pkg::func_t   func;
	lti_pkg::letter_t letter;
	logic             last_letter;
	logic             result_valid;
	logic             result_stall;
	logic             found;
	logic             status;

	trie_scoreboard   sb;
	int               send_idle_pct;
	int               recv_idle_pct;
	logic             hold_request;
	int               items_sent;
	int               words_sent;
	lti_pkg::letter_t kept [16];
	int unsigned      kept_len;
	int               quiet_cycles;

	letter_trie_insert_search #(
		.NODE_COUNT   (NODES),
		.ALPHABET_SIZE(ALPHA)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.letter_valid(letter_valid),
		.letter_stall(letter_stall),
		.func        (func),
		.letter      (letter),
		.last_letter (last_letter),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.found       (found),
		.status      (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (letter_valid && !letter_stall)
			sb.note_letter(func, letter, last_letter);
		if (result_valid && !result_stall)
			sb.check_result(found, status);
	end

	initial begin
		int unsigned hold_left;
		bit          hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((letter_valid && !letter_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: timeout after %0d quiet cycles", quiet_cycles);
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_letter(lti_pkg::func_t op, lti_pkg::letter_t l, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			letter_valid <= 1'b0;
			@(posedge clk);
		end
		letter_valid <= 1'b1;
		func <= op;
		letter <= l;
		last_letter <= last;
		do
			@(posedge clk);
		while (letter_stall);
		items_sent++;
		if (last)
			words_sent++;
	endtask

	// hold the letter channel until every predicted result has come back
	task automatic drain_results();
		letter_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic send_word(bit fill);
		int unsigned      len;
		int unsigned      roll;
		lti_pkg::func_t   op;
		bit               mixed;
		bit               reuse;
		lti_pkg::letter_t l;
		len = fill ? $urandom_range(16, 12) : $urandom_range(8, 1);
		roll = $urandom_range(99);
		op = roll < 45 ? lti_pkg::FUNC_INSERT : roll < 75 ? lti_pkg::FUNC_SEARCH :
			roll < 95 ? lti_pkg::FUNC_PREFIX : FUNC_SPARE;
		if (fill)
			op = lti_pkg::FUNC_INSERT;
		mixed = !fill && ($urandom_range(7) == 0);
		reuse = !fill && op != lti_pkg::FUNC_INSERT && kept_len > 0 &&
			$urandom_range(2) == 0;
		if (reuse)
			len = (op == lti_pkg::FUNC_SEARCH) ? kept_len : $urandom_range(kept_len, 1);
		for (int i = 0; i < len; i++) begin
			roll = $urandom_range(99);
			if (reuse)
				l = kept[i];
			else if (fill)
				l = lti_pkg::letter_t'($urandom_range(ALPHA - 1));
			else if (roll < 4)
				l = lti_pkg::letter_t'($urandom_range(31, ALPHA));
			else if (op == lti_pkg::FUNC_INSERT && roll < 55 || roll < 20)
				l = lti_pkg::letter_t'($urandom_range(ALPHA - 1));
			else
				l = lti_pkg::letter_t'($urandom_range(3));
			if (op == lti_pkg::FUNC_INSERT && !mixed)
				kept[i] = l;
			send_letter(mixed ? lti_pkg::func_t'($urandom_range(3)) : op, l, i == len - 1);
		end
		if (op == lti_pkg::FUNC_INSERT && !mixed)
			kept_len = len;
	endtask

	initial begin
		int target;
		sb = new();
		arst_n = 1'b0;
		letter_valid = 1'b0;
		func = lti_pkg::FUNC_INSERT;
		letter = '0;
		last_letter = 1'b0;
		hold_request = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		items_sent = 0;
		words_sent = 0;
		kept_len = 0;
		quiet_cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed words
		send_letter(lti_pkg::FUNC_SEARCH, 5'd0, 1'b1);
		send_letter(lti_pkg::FUNC_INSERT, 5'd0, 1'b1);
		send_letter(lti_pkg::FUNC_SEARCH, 5'd0, 1'b1);
		send_letter(lti_pkg::FUNC_INSERT, lti_pkg::letter_t'(ALPHA - 1), 1'b0);
		send_letter(lti_pkg::FUNC_INSERT, lti_pkg::letter_t'(ALPHA - 1), 1'b1);
		send_letter(lti_pkg::FUNC_PREFIX, lti_pkg::letter_t'(ALPHA - 1), 1'b1);
		send_letter(lti_pkg::FUNC_SEARCH, lti_pkg::letter_t'(ALPHA - 1), 1'b1);
		send_letter(FUNC_SPARE, lti_pkg::letter_t'(ALPHA - 1), 1'b1);
		send_letter(lti_pkg::FUNC_SEARCH, '1, 1'b1);
		send_letter(lti_pkg::FUNC_INSERT, lti_pkg::letter_t'(ALPHA), 1'b0);
		send_letter(lti_pkg::FUNC_INSERT, 5'd0, 1'b1);
		send_letter(lti_pkg::FUNC_SEARCH, 5'd1, 1'b0);
		send_letter(lti_pkg::FUNC_INSERT, 5'd2, 1'b1);
		send_letter(lti_pkg::FUNC_PREFIX, lti_pkg::letter_t'(ALPHA - 1), 1'b0);
		send_letter(lti_pkg::FUNC_INSERT, 5'd0, 1'b1);
		send_letter(lti_pkg::FUNC_SEARCH, lti_pkg::letter_t'(ALPHA - 1), 1'b0);
		send_letter(lti_pkg::FUNC_SEARCH, 5'd0, 1'b1);
		send_letter(lti_pkg::FUNC_INSERT, 5'd16, 1'b1);
		send_letter(lti_pkg::FUNC_PREFIX, 5'd16, 1'b0);
		send_letter(lti_pkg::FUNC_PREFIX, 5'd1, 1'b1);
		drain_results();

		// sender sparse, receiver busy
		send_idle_pct = 21;
		recv_idle_pct = 51;
		target = items_sent + 125;
		while (items_sent < target)
			send_word(1'b0);
		drain_results();

		// roles swapped; receiver holds off first so the block backs up
		send_idle_pct = 51;
		recv_idle_pct = 21;
		hold_request <= 1'b1;
		target = items_sent + 125;
		while (items_sent < target)
			send_word(1'b0);
		drain_results();

		// no idling: fill the node pool, then keep working against it
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (sb.used < NODES)
			send_word(1'b1);
		target = items_sent + 60;
		while (items_sent < target)
			send_word(1'b0);
		drain_results();
		repeat (20) @(posedge clk);

		$display("tb: %0d letters in %0d words, %0d results checked",
			items_sent, words_sent, sb.results);
		$display("tb: %0d searches hit, %0d inserts hit the full pool, %0d nodes used",
			sb.hits, sb.full_inserts, sb.used);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/lti_pkg.sv
sv/letter_trie_insert_search.sv
bench/letter_trie_insert_search_tb.sv
